### hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/artt_pkg.sv
package artt_pkg;

   localparam int unsigned MAX_REGIONS_DEF = 8;
   localparam int unsigned ADDR_W = 64;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned MODE_W = 2;

   localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GUEST = 2'd1;
   localparam logic [MODE_W-1:0] MODE_USER = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [INDEX_W-1:0] region_index;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] region_length;
      logic [ADDR_W-1:0] user_base;
      logic [ADDR_W-1:0] map_base;
      logic [ADDR_W-1:0] map_offset;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] translated_address;
      logic hit;
      logic [INDEX_W-1:0] matched_index;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] guest_base;
      logic [ADDR_W-1:0] user_base;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] host_base;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic ram_write;
      logic calc;
      logic scan_inc;
      logic set_load;
      logic set_hit;
      logic set_miss;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic is_xlate;
      logic index_ok;
      logic scan_none;
      logic match;
      logic scan_last;
   } sts_type;

endpackage

### hdl/address_region_translation_table_unit.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_data (load or translate)
// rsp       out        rsp_valid / rsp_ready  rsp_data (host address, hit, index)
// csr       in         csr_wr_en              csr_wr_data (region count)
//
// a load, or a request that searches nothing, passes through the decode and
// finish states to its result in the output register
// a translate runs the read, calc and check states for each entry scanned up to
// and including the first match (at most min(region count, MAX_REGIONS)), as
// the table has a single read port and registered read data
// reset is synchronous; it clears the region count and all control state
// a new request is taken while an earlier result still waits in the output
// register; a stalled rsp side holds the next result in its finish state

`include "assert_macros.svh"

module address_region_translation_table_unit #(
   parameter int unsigned MAX_REGIONS = artt_pkg::MAX_REGIONS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  artt_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output artt_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [artt_pkg::COUNT_W-1:0] csr_wr_data
);

   artt_pkg::cmd_type cmd;
   artt_pkg::sts_type sts;

   artt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   artt_dp #(
      .MAX_REGIONS(MAX_REGIONS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_data   (req_data),
      .rsp_data   (rsp_data),
      .cmd        (cmd),
      .sts        (sts)
   );

   `ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   `ASSERT_SAME(a_no_result_overwrite, clock, reset, cmd.rsp_load, !rsp_valid || rsp_ready, "waiting result overwritten")
   `ASSERT_SAME(a_write_only_on_load, clock, reset, cmd.ram_write, sts.is_load && sts.index_ok, "table written outside a valid load")

endmodule

### hdl/artt_ram.sv
module artt_ram #(
   parameter int unsigned WIDTH = 256,
   parameter int unsigned DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/artt_dp.sv
module artt_dp #(
   parameter int unsigned MAX_REGIONS = artt_pkg::MAX_REGIONS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [artt_pkg::COUNT_W-1:0] csr_wr_data,
   input  artt_pkg::req_type            req_data,
   output artt_pkg::rsp_type            rsp_data,
   input  artt_pkg::cmd_type            cmd,
   output artt_pkg::sts_type            sts
);

   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int CMP_W = (CNT_W > int'(artt_pkg::COUNT_W)) ? CNT_W : int'(artt_pkg::COUNT_W);
   localparam logic [CMP_W-1:0] LIMIT_MAX = CMP_W'(MAX_REGIONS);
   localparam logic [7:0] MAX_B = 8'(MAX_REGIONS);

   artt_pkg::req_type item_ff, item_in;
   logic [artt_pkg::ADDR_W-1:0] host_sum_ff, host_sum_in;
   logic [artt_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [artt_pkg::ADDR_W-1:0] end_ff, end_in;
   logic [artt_pkg::ADDR_W-1:0] off_ff, off_in;
   logic [artt_pkg::ADDR_W-1:0] host_ff, host_in;
   logic ge_ff, ge_in;
   artt_pkg::rsp_type res_ff, res_in;
   artt_pkg::rsp_type rsp_ff, rsp_in;

   artt_pkg::entry_type wr_entry;
   artt_pkg::entry_type rd_entry;
   logic [artt_pkg::ADDR_W-1:0] base;
   logic [CMP_W-1:0] scan_next;

   artt_ram #(
      .WIDTH($bits(artt_pkg::entry_type)),
      .DEPTH(MAX_REGIONS)
   ) u_table (
      .clock  (clock),
      .wr_en  (cmd.ram_write),
      .wr_addr(IDX_W'(item_ff.region_index)),
      .wr_data(wr_entry),
      .rd_addr(scan_ff[IDX_W-1:0]),
      .rd_data(rd_entry)
   );

   always_comb begin
      wr_entry.guest_base = item_ff.address;
      wr_entry.user_base = item_ff.user_base;
      wr_entry.length = item_ff.region_length;
      wr_entry.host_base = host_sum_ff;
   end

   // one entry compared per pass: bounds first, then offset plus host base
   always_comb begin
      base = (item_ff.mode == artt_pkg::MODE_GUEST) ? rd_entry.guest_base
                                                    : rd_entry.user_base;
      end_in = end_ff;
      off_in = off_ff;
      host_in = host_ff;
      ge_in = ge_ff;
      if (cmd.calc) begin
         end_in = base + rd_entry.length;
         off_in = item_ff.address - base;
         host_in = rd_entry.host_base;
         ge_in = item_ff.address >= base;
      end
   end

   always_comb begin
      item_in = item_ff;
      host_sum_in = host_sum_ff;
      if (cmd.capture) begin
         item_in = req_data;
         host_sum_in = req_data.map_base + req_data.map_offset;
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.capture) begin
         scan_in = '0;
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + CNT_W'(1);
      end
   end

   assign count_in = csr_wr_en ? csr_wr_data : count_ff;

   always_comb begin
      res_in = res_ff;
      if (cmd.set_load) begin
         res_in.translated_address = '0;
         res_in.hit = 1'b1;
         res_in.matched_index = item_ff.region_index;
      end else if (cmd.set_hit) begin
         res_in.translated_address = off_ff + host_ff;
         res_in.hit = 1'b1;
         res_in.matched_index = artt_pkg::INDEX_W'(scan_ff);
      end else if (cmd.set_miss) begin
         res_in = '0;
      end
   end

   assign rsp_in = cmd.rsp_load ? res_ff : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff <= '0;
      end else begin
         count_ff <= count_in;
         scan_ff <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      host_sum_ff <= host_sum_in;
      end_ff <= end_in;
      off_ff <= off_in;
      host_ff <= host_in;
      ge_ff <= ge_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign scan_next = CMP_W'(scan_ff) + CMP_W'(1);

   always_comb begin
      sts.is_load = item_ff.mode == artt_pkg::MODE_LOAD;
      sts.is_xlate = (item_ff.mode == artt_pkg::MODE_GUEST) ||
                     (item_ff.mode == artt_pkg::MODE_USER);
      sts.index_ok = {5'b0, item_ff.region_index} < MAX_B;
      sts.scan_none = count_ff == '0;
      sts.match = ge_ff && (item_ff.address < end_ff);
      // count above the table size saturates
      sts.scan_last = (scan_next >= CMP_W'(count_ff)) || (scan_next >= LIMIT_MAX);
   end

   assign rsp_data = rsp_ff;

endmodule

### hdl/artt_ctrl.sv
module artt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output artt_pkg::cmd_type cmd,
   input  artt_pkg::sts_type sts
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_READ   = 6'b000100,
      S_CALC   = 6'b001000,
      S_CHECK  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_load) begin
               if (sts.index_ok) begin
                  cmd.ram_write = 1'b1;
                  cmd.set_load = 1'b1;
               end else begin
                  cmd.set_miss = 1'b1;
               end
               state_in = S_FINISH;
            end else if (sts.is_xlate && !sts.scan_none) begin
               state_in = S_READ;
            end else begin
               cmd.set_miss = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.match) begin
               cmd.set_hit = 1'b1;
               state_in = S_FINISH;
            end else if (sts.scan_last) begin
               cmd.set_miss = 1'b1;
               state_in = S_FINISH;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in = S_READ;
            end
         end
         S_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
